// ----- hdl/tcsp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcsp_pkg
// Shared types and constants for the three-channel servo pulse generator.
// ---------------------------------------------------------------------------
package tcsp_pkg;

	// Sizes
	localparam int NUM_SERVOS  = 3;
	localparam int SAMPLE_BITS = 8;
	localparam int WIDTH_BITS  = 8;
	localparam int PERIOD_BITS = 16;
	localparam int PULSE_BITS  = WIDTH_BITS + 1;
	localparam int SRV_W       = $clog2(NUM_SERVOS + 1);
	localparam int IDX_W       = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
	localparam int PROD_W      = SAMPLE_BITS + WIDTH_BITS;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// Register reset values
	localparam logic [PERIOD_BITS-1:0] FRAME_PERIOD_RST = PERIOD_BITS'(2000);
	localparam logic [WIDTH_BITS-1:0]  MIN_WIDTH_RST    = WIDTH_BITS'(98);
	localparam logic [WIDTH_BITS-1:0]  MAX_WIDTH_RST    = WIDTH_BITS'(199);

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_PERIOD = 2'd0,
		REG_MIN_WIDTH    = 2'd1,
		REG_MAX_WIDTH    = 2'd2
	} cfg_reg_t;

	// Input item
	typedef struct packed {
		logic                   req_type;
		logic [SAMPLE_BITS-1:0] sample;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic [NUM_SERVOS-1:0] servo_pins;
		logic [IDX_W-1:0]      next_channel;
		logic                  frame_start;
	} out_item_t;

	// Request to the width mapper: product sample*|max-min|, slope and base
	typedef struct packed {
		logic [PROD_W-1:0]     prod;
		logic                  descend;
		logic [WIDTH_BITS-1:0] base;
	} map_req_t;

endpackage
`default_nettype wire

// ----- hdl/three_channel_servo_pwm.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// three_channel_servo_pwm
// Servo frame generator: stores converter samples round-robin, maps them to
// pulse widths and drives the servo pulses one after another each frame.
// ---------------------------------------------------------------------------
//  Channel | Handshake             | Payload
//  --------+-----------------------+------------------------------------
//  in      | in_valid / in_ready   | in_data  (req_type, sample)
//  out     | out_valid / out_ready | out_data (servo_pins, next_channel,
//          |                       |           frame_start)
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One item per cycle unless the output or a remap stalls; each result
//  passes input register, then result register. The sample multiplier sits in
//  front of the input register, the divide-by-full-scale behind it.
//  After a configuration write the stored slot widths are remapped, one slot
//  a cycle while the input register is free, with in_ready low meanwhile.
//  A stalled output holds the result register; the input register keeps
//  one more item, then in_ready drops. cfg_ready is always high.
//  Reset restores register defaults and idles the pulse sequencer.
// ---------------------------------------------------------------------------
module three_channel_servo_pwm (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    in_valid,
	output logic                                   in_ready,
	input  wire tcsp_pkg::in_item_t                in_data,
	output logic                                   out_valid,
	input  wire                                    out_ready,
	output tcsp_pkg::out_item_t                    out_data,
	input  wire                                    cfg_valid,
	output logic                                   cfg_ready,
	input  wire [tcsp_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire [tcsp_pkg::CFG_DATA_W-1:0]         cfg_data
);

	localparam int NS  = tcsp_pkg::NUM_SERVOS;
	localparam int WB  = tcsp_pkg::WIDTH_BITS;
	localparam int PB  = tcsp_pkg::PERIOD_BITS;
	localparam int CB  = tcsp_pkg::PULSE_BITS;
	localparam int SW  = tcsp_pkg::SRV_W;
	localparam int IW  = tcsp_pkg::IDX_W;
	localparam int SB  = tcsp_pkg::SAMPLE_BITS;
	localparam int PW  = tcsp_pkg::PROD_W;
	localparam logic [SW-1:0] IDLE     = SW'(NS);
	localparam logic [IW-1:0] LAST_IDX = IW'(NS - 1);

	// Configuration registers
	logic [PB-1:0] period_q;
	logic [WB-1:0] min_q;
	logic [WB-1:0] max_q;
	logic          cfg_xfer;

	// Remap sweep after a configuration write
	logic          sweep_q;
	logic [IW-1:0] sweep_idx_q;

	// Input register stage
	logic                 valid_s1;
	logic                 sweep_s1;
	tcsp_pkg::in_item_t   item_s1;
	logic [PW-1:0]        prod_s1;
	logic [IW-1:0]        slot_s1;

	// Block state
	logic [IW-1:0]            ptr_q;
	logic [NS-1:0][SB-1:0]    stored_q;
	logic [NS-1:0][WB-1:0]    mapped_q;
	logic [NS-1:0][WB-1:0]    latched_q;
	logic [PB-1:0]            frame_q;
	logic [CB-1:0]            pulse_q;
	logic [SW-1:0]            active_q;

	// Result register
	logic                 out_valid_q;
	tcsp_pkg::out_item_t  out_q;

	// Handshake and datapath nets
	logic                 adv;
	logic                 s1_go;
	logic                 s1_free;
	logic                 load_s1;
	logic                 item_go;
	logic                 descend;
	logic [WB-1:0]        diff;
	logic [SB-1:0]        mul_a;
	logic [PW-1:0]        prod_d;
	tcsp_pkg::map_req_t   map_req;
	logic [WB-1:0]        map_width;

	// Next-state nets
	logic                 fs;
	logic [SW-1:0]        act_cur;
	logic [CB-1:0]        pulse_cur;
	logic [NS-1:0][WB-1:0] lat_cur;
	logic [WB-1:0]        cur_w;
	logic [PB:0]          frame_inc;
	logic [IW-1:0]        ptr_d;
	logic [SW-1:0]        active_d;
	logic [CB-1:0]        pulse_d;
	logic [PB-1:0]        frame_d;
	logic                 latch_en;
	tcsp_pkg::out_item_t  res;

	// Handshakes
	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign adv       = !out_valid_q || out_ready;
	assign s1_go     = valid_s1 && (sweep_s1 || adv);
	assign s1_free   = !valid_s1 || s1_go;
	assign in_ready  = s1_free && !sweep_q;
	assign load_s1   = s1_free && (sweep_q || in_valid);
	assign item_go   = valid_s1 && !sweep_s1 && adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= tcsp_pkg::FRAME_PERIOD_RST;
			min_q    <= tcsp_pkg::MIN_WIDTH_RST;
			max_q    <= tcsp_pkg::MAX_WIDTH_RST;
		end else if (cfg_xfer) begin
			unique case (cfg_index)
				tcsp_pkg::REG_FRAME_PERIOD: period_q <= PB'(cfg_data);
				tcsp_pkg::REG_MIN_WIDTH:    min_q    <= WB'(cfg_data);
				tcsp_pkg::REG_MAX_WIDTH:    max_q    <= WB'(cfg_data);
				default: ;
			endcase
		end
	end

	// Remap sweep: one slot per cycle through the input stage while it is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= 1'b0;
			sweep_idx_q <= '0;
		end else if (cfg_xfer) begin
			sweep_q     <= 1'b1;
			sweep_idx_q <= '0;
		end else if (sweep_q && s1_free) begin
			if (sweep_idx_q == LAST_IDX) begin
				sweep_q <= 1'b0;
			end else begin
				sweep_idx_q <= sweep_idx_q + 1'b1;
			end
		end
	end

	// Slope and product ahead of the input register
	always_comb begin
		descend = max_q < min_q;
		diff    = descend ? min_q - max_q : max_q - min_q;
		mul_a   = sweep_q ? stored_q[sweep_idx_q] : in_data.sample;
		prod_d  = PW'(mul_a) * PW'(diff);
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			sweep_s1 <= sweep_q;
			item_s1  <= in_data;
			prod_s1  <= prod_d;
			slot_s1  <= sweep_idx_q;
		end
	end

	// Divide by full scale and offset
	assign map_req = '{prod: prod_s1, descend: descend, base: min_q};

	tcsp_map u_map (
		.req   (map_req),
		.width (map_width)
	);

	// Pulse sequencer and result
	always_comb begin
		fs        = (frame_q == '0);
		act_cur   = fs ? '0 : active_q;
		pulse_cur = fs ? '0 : pulse_q;
		lat_cur   = fs ? mapped_q : latched_q;
		cur_w     = lat_cur[act_cur[IW-1:0]];
		frame_inc = {1'b0, frame_q} + 1'b1;
		ptr_d     = (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
		active_d  = active_q;
		pulse_d   = pulse_q;
		frame_d   = frame_q;
		latch_en  = 1'b0;
		res       = '0;
		if (item_s1.req_type) begin
			// sample: time stands still
			res.servo_pins   = (active_q < IDLE) ? NS'(1) << active_q : '0;
			res.next_channel = ptr_d;
		end else begin
			latch_en         = fs;
			res.frame_start  = fs;
			res.servo_pins   = (act_cur < IDLE) ? NS'(1) << act_cur : '0;
			res.next_channel = ptr_q;
			active_d         = act_cur;
			pulse_d          = pulse_cur;
			if (act_cur < IDLE) begin
				if (pulse_cur >= CB'(cur_w)) begin
					pulse_d  = '0;
					active_d = act_cur + 1'b1;
				end else begin
					pulse_d  = pulse_cur + 1'b1;
				end
			end
			frame_d = (frame_inc >= {1'b0, period_q}) ? '0 : frame_inc[PB-1:0];
		end
	end

	// Block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			stored_q  <= '0;
			mapped_q  <= {NS{tcsp_pkg::MIN_WIDTH_RST}};
			latched_q <= '0;
			frame_q   <= '0;
			pulse_q   <= '0;
			active_q  <= IDLE;
		end else begin
			if (valid_s1 && sweep_s1) begin
				mapped_q[slot_s1] <= map_width;
			end
			if (item_go) begin
				if (item_s1.req_type) begin
					stored_q[ptr_q] <= item_s1.sample;
					mapped_q[ptr_q] <= map_width;
					ptr_q           <= ptr_d;
				end else begin
					if (latch_en) begin
						latched_q <= mapped_q;
					end
					active_q <= active_d;
					pulse_q  <= pulse_d;
					frame_q  <= frame_d;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_go) begin
			out_q <= res;
		end
	end

	// Checks
	a_pins_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot0(out_q.servo_pins))
		else $error("more than one servo pin high");

	a_frame_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.frame_start |-> out_q.servo_pins == NS'(1))
		else $error("frame start without servo 0 active");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= LAST_IDX && active_q <= IDLE)
		else $error("channel pointer or active servo out of range");

	a_cfg_remap: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_xfer |=> !in_ready && sweep_q)
		else $error("input taken while widths are being remapped");

endmodule
`default_nettype wire

// ----- hdl/tcsp_map.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tcsp_map
// Finishes the sample-to-width mapping: divides the registered product by
// full scale (2^n - 1) without a divider and adds it to or takes it from min.
// ---------------------------------------------------------------------------
module tcsp_map (
	input  wire tcsp_pkg::map_req_t               req,
	output logic [tcsp_pkg::WIDTH_BITS-1:0]      width
);

	localparam int N  = tcsp_pkg::SAMPLE_BITS;
	localparam int PW = tcsp_pkg::PROD_W + 1;
	localparam logic [PW-1:0] FULL = PW'((1 << tcsp_pkg::SAMPLE_BITS) - 1);

	logic [PW-1:0]                   sum;
	logic [PW-1:0]                   q0_w;
	logic [PW-1:0]                   rem;
	logic [tcsp_pkg::WIDTH_BITS-1:0] q0;
	logic [tcsp_pkg::WIDTH_BITS-1:0] q;

	// x/(2^n-1) ~ (x + x>>n) >> n, low by at most one; fix with the remainder
	always_comb begin
		sum   = PW'(req.prod) + PW'(req.prod >> N);
		q0    = tcsp_pkg::WIDTH_BITS'(sum >> N);
		q0_w  = PW'(q0);
		rem   = PW'(req.prod) - (q0_w << N) + q0_w;
		q     = (rem >= FULL) ? q0 + 1'b1 : q0;
		width = req.descend ? req.base - q : req.base + q;
	end

endmodule
`default_nettype wire
